// ===== hdl/assert_macros.svh =====
// Assertion helpers included by the sequencer module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define TFCS_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
`define TFCS_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) (prop)) \
      else $error("assertion failed");
`else
`define TFCS_ASSERT(lbl, clk, rst, prop)
`define TFCS_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== hdl/tfcs_pkg.sv =====
package tfcs_pkg;

   localparam int CMD_DEPTH  = 4096;
   localparam int CHUNK_MAX  = 63;
   localparam int ADDR_W     = $clog2(CMD_DEPTH);
   localparam int CNT_W      = $clog2(CMD_DEPTH + 1);
   localparam int CHUNK_W    = $clog2(CHUNK_MAX + 1);
   localparam int CAP_W      = 13;
   localparam int TMO_W      = 20;
   localparam int LEN_W      = 13;
   localparam int BURST_W    = 16;
   localparam int EXP_W      = 32;
   localparam int PADDR_W    = 3;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(4096);
   localparam logic [TMO_W-1:0] TMO_RESET = TMO_W'(1000 * 1000);

   localparam logic REG_CAPACITY = 1'b0;
   localparam logic REG_TIMEOUT  = 1'b1;

   localparam int ST_VALID  = 7;
   localparam int ST_READY  = 6;
   localparam int ST_DATA   = 4;
   localparam int ST_EXPECT = 3;

   localparam logic [1:0] OP_CMD    = 2'd0;
   localparam logic [1:0] OP_STATUS = 2'd1;
   localparam logic [1:0] OP_RESP   = 2'd2;

   localparam logic [2:0] ACT_WRITE_DATA  = 3'd1;
   localparam logic [2:0] ACT_WRITE_GO    = 3'd2;
   localparam logic [2:0] ACT_READ_DATA   = 3'd3;
   localparam logic [2:0] ACT_WRITE_READY = 3'd4;
   localparam logic [2:0] ACT_READ_STATUS = 3'd5;
   localparam logic [2:0] ACT_DONE        = 3'd6;
   localparam logic [2:0] ACT_ERROR       = 3'd7;

   localparam logic [2:0] ERR_NONE          = 3'd0;
   localparam logic [2:0] ERR_READY_TIMEOUT = 3'd1;
   localparam logic [2:0] ERR_FEED          = 3'd2;
   localparam logic [2:0] ERR_END_STATUS    = 3'd3;
   localparam logic [2:0] ERR_LENGTH        = 3'd4;
   localparam logic [2:0] ERR_READ_TIMEOUT  = 3'd5;

   typedef struct packed {
      logic [1:0]  operation;
      logic [7:0]  cmd_byte;
      logic        cmd_last;
      logic [23:0] status_word;
      logic [7:0]  resp_byte;
   } req_type;

   typedef struct packed {
      logic [2:0]       action;
      logic [7:0]       out_byte;
      logic             resp_valid;
      logic [LEN_W-1:0] resp_length;
      logic [2:0]       error_code;
      logic             last;
   } rsp_type;

   typedef struct packed {
      logic [CAP_W-1:0] capacity;
      logic [TMO_W-1:0] timeout;
   } cfg_type;

   function automatic rsp_type make_rsp(logic [2:0] act, logic [7:0] byt, logic rv,
                                        logic [LEN_W-1:0] len, logic [2:0] err);
      rsp_type r;
      r.action      = act;
      r.out_byte    = byt;
      r.resp_valid  = rv;
      r.resp_length = len;
      r.error_code  = err;
      r.last        = 1'b1;
      return r;
   endfunction

endpackage

// ===== hdl/tfcs_csr.sv =====
module tfcs_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [tfcs_pkg::PADDR_W-1:0]  paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready,
   output tfcs_pkg::cfg_type             cfg
);

   logic [tfcs_pkg::CAP_W-1:0] capacity_ff, capacity_in;
   logic [tfcs_pkg::TMO_W-1:0] timeout_ff, timeout_in;
   logic                       wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;

   always_comb begin
      capacity_in = capacity_ff;
      timeout_in  = timeout_ff;
      if (wr_en && paddr[2] == tfcs_pkg::REG_CAPACITY) begin
         capacity_in = pwdata[tfcs_pkg::CAP_W-1:0];
      end
      if (wr_en && paddr[2] == tfcs_pkg::REG_TIMEOUT) begin
         timeout_in = pwdata[tfcs_pkg::TMO_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= tfcs_pkg::CAP_RESET;
         timeout_ff  <= tfcs_pkg::TMO_RESET;
      end else begin
         capacity_ff <= capacity_in;
         timeout_ff  <= timeout_in;
      end
   end

   assign prdata = (paddr[2] == tfcs_pkg::REG_TIMEOUT)
                   ? {{(32 - tfcs_pkg::TMO_W){1'b0}}, timeout_ff}
                   : {{(32 - tfcs_pkg::CAP_W){1'b0}}, capacity_ff};

   assign cfg.capacity = capacity_ff;
   assign cfg.timeout  = timeout_ff;

endmodule

// ===== hdl/tpm_fifo_command_sequencer.sv =====
// Host-side sequencer for a FIFO-style TPM interface.
// req channel: one transaction per command byte, status word read or response
// byte read. rsp channel: the bus actions the host must perform next (write
// data, write GO, read data, write ready, read status), delivered response
// bytes, and a done or error result; the last result of a transaction has
// last set. Command bytes are held in a 4096-byte store until the final one.
// Each transaction is latched, decoded by the phase controller in S_EXEC,
// and its results are then issued one at a time through an output register;
// a data burst reads each command byte from the store before issuing it.
// req_ready is low from acceptance until the last result is in the output
// register; the next transaction can be accepted while that result waits.
// A stalled rsp_ready holds the output register and pauses the sequence.
// Reset (synchronous) returns to the idle phase with all counts cleared and
// the registers at capacity 4096 and timeout 1000000; no clearing pass runs.
// Configuration must be written through the APB port only while no
// transaction is open; the block itself does not enforce this.
module tpm_fifo_command_sequencer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  tfcs_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output tfcs_pkg::rsp_type             rsp_data,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [tfcs_pkg::PADDR_W-1:0]  paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);

   `include "assert_macros.svh"

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_EXEC  = 3'd1;
   localparam logic [2:0] S_PRE   = 3'd2;
   localparam logic [2:0] S_MREAD = 3'd3;
   localparam logic [2:0] S_MEMIT = 3'd4;
   localparam logic [2:0] S_FINAL = 3'd5;

   localparam logic [3:0] PH_IDLE       = 4'd0;
   localparam logic [3:0] PH_WAIT_READY = 4'd1;
   localparam logic [3:0] PH_FEED_BURST = 4'd2;
   localparam logic [3:0] PH_FEED_CHECK = 4'd3;
   localparam logic [3:0] PH_LAST_CHECK = 4'd4;
   localparam logic [3:0] PH_RESP_WAIT  = 4'd5;
   localparam logic [3:0] PH_RESP_BURST = 4'd6;
   localparam logic [3:0] PH_READING    = 4'd7;
   localparam logic [3:0] PH_RESP_CHECK = 4'd8;
   localparam logic [3:0] PH_READY1     = 4'd9;
   localparam logic [3:0] PH_READY2     = 4'd10;

   tfcs_pkg::cfg_type cfg;

   tfcs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   logic [2:0]                    state_ff, state_in;
   tfcs_pkg::req_type             in_ff;
   logic [3:0]                    phase_ff, phase_in;
   logic [tfcs_pkg::CNT_W-1:0]    cmd_count_ff, cmd_count_in;
   logic [tfcs_pkg::CNT_W-1:0]    send_offset_ff, send_offset_in;
   logic [tfcs_pkg::TMO_W-1:0]    poll_count_ff, poll_count_in;
   logic [tfcs_pkg::BURST_W-1:0]  read_credit_ff, read_credit_in;
   logic [tfcs_pkg::LEN_W-1:0]    recv_offset_ff, recv_offset_in;
   logic [tfcs_pkg::EXP_W-1:0]    expected_len_ff, expected_len_in;

   logic                          pre_in;
   logic [2:0]                    pre_action_ff, pre_action_in;
   logic [tfcs_pkg::CHUNK_W-1:0]  plan_n_ff, plan_n_in;
   logic                          final_vld_ff, final_vld_in;
   tfcs_pkg::rsp_type             final_ff, final_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   tfcs_pkg::rsp_type             rsp_data_ff, rsp_data_in;

   logic [7:0]                    cmd_mem [tfcs_pkg::CMD_DEPTH];
   logic [7:0]                    mem_q_ff;
   logic                          mem_we;

   logic                          exec_en;
   logic                          out_free;
   logic                          rsp_load;

   assign exec_en   = (state_ff == S_EXEC);
   assign req_ready = (state_ff == S_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_load  = out_free && (state_ff == S_PRE || state_ff == S_MEMIT ||
                                   state_ff == S_FINAL);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Phase controller: decodes the latched transaction against the current phase.
   always_comb begin
      logic [tfcs_pkg::BURST_W-1:0] b;
      logic [tfcs_pkg::TMO_W:0]     poll_inc;
      logic [tfcs_pkg::EXP_W-1:0]   limit;
      logic [tfcs_pkg::EXP_W-1:0]   limit_nxt;
      logic [tfcs_pkg::EXP_W-1:0]   rem;
      logic [tfcs_pkg::EXP_W-1:0]   n;
      logic [tfcs_pkg::EXP_W-1:0]   exp_nxt;
      logic [tfcs_pkg::LEN_W-1:0]   recv_nxt;
      logic [tfcs_pkg::BURST_W-1:0] credit_nxt;
      logic [23:0]                  s;
      logic                         poll_req, feed_req, start_req, fin_req;
      logic                         done_req, fail_req, clear_req;
      logic [2:0]                   poll_code, fail_code;

      s         = in_ff.status_word;
      b         = s[23:8];
      poll_inc  = {1'b0, poll_count_ff} + 1'b1;
      limit     = (recv_offset_ff < tfcs_pkg::LEN_W'(6))
                  ? tfcs_pkg::EXP_W'(cfg.capacity)
                  : expected_len_ff;
      rem       = tfcs_pkg::EXP_W'(cmd_count_ff - send_offset_ff - 1'b1);
      n         = rem;
      exp_nxt   = expected_len_ff;
      recv_nxt  = recv_offset_ff + 1'b1;
      credit_nxt = (read_credit_ff != '0) ? read_credit_ff - 1'b1 : read_credit_ff;
      limit_nxt = '0;
      poll_req  = 1'b0;
      feed_req  = 1'b0;
      start_req = 1'b0;
      fin_req   = 1'b0;
      done_req  = 1'b0;
      fail_req  = 1'b0;
      clear_req = 1'b0;
      poll_code = tfcs_pkg::ERR_NONE;
      fail_code = tfcs_pkg::ERR_NONE;

      phase_in        = phase_ff;
      cmd_count_in    = cmd_count_ff;
      poll_count_in   = poll_count_ff;
      read_credit_in  = read_credit_ff;
      recv_offset_in  = recv_offset_ff;
      expected_len_in = expected_len_ff;
      pre_in          = 1'b0;
      pre_action_in   = tfcs_pkg::ACT_WRITE_READY;
      plan_n_in       = '0;
      final_vld_in    = 1'b0;
      final_in        = tfcs_pkg::make_rsp(tfcs_pkg::ACT_READ_STATUS, 8'd0, 1'b0, '0,
                                           tfcs_pkg::ERR_NONE);
      mem_we          = 1'b0;
      send_offset_in  = send_offset_ff;

      case (in_ff.operation)
         tfcs_pkg::OP_CMD: begin
            if (phase_ff == PH_IDLE) begin
               if (cmd_count_ff >= tfcs_pkg::CNT_W'(tfcs_pkg::CMD_DEPTH)) begin
                  fail_req  = 1'b1;
                  fail_code = tfcs_pkg::ERR_FEED;
               end else begin
                  mem_we       = 1'b1;
                  cmd_count_in = cmd_count_ff + 1'b1;
                  if (in_ff.cmd_last) begin
                     expected_len_in = tfcs_pkg::EXP_W'(cfg.capacity);
                     send_offset_in  = '0;
                     recv_offset_in  = '0;
                     poll_count_in   = '0;
                     phase_in        = PH_WAIT_READY;
                     final_vld_in    = 1'b1;
                  end
               end
            end
         end
         tfcs_pkg::OP_STATUS: begin
            case (phase_ff)
               PH_WAIT_READY: begin
                  if (!s[tfcs_pkg::ST_READY]) begin
                     poll_req  = 1'b1;
                     poll_code = tfcs_pkg::ERR_READY_TIMEOUT;
                  end else if (b != '0) begin
                     feed_req = 1'b1;
                  end else begin
                     poll_count_in = '0;
                     phase_in      = PH_FEED_BURST;
                     final_vld_in  = 1'b1;
                  end
               end
               PH_FEED_BURST: begin
                  if (b != '0) begin
                     feed_req = 1'b1;
                  end else begin
                     poll_req  = 1'b1;
                     poll_code = tfcs_pkg::ERR_FEED;
                  end
               end
               PH_FEED_CHECK: begin
                  if (!s[tfcs_pkg::ST_VALID]) begin
                     poll_req  = 1'b1;
                     poll_code = tfcs_pkg::ERR_FEED;
                  end else if (!s[tfcs_pkg::ST_EXPECT]) begin
                     fail_req  = 1'b1;
                     fail_code = tfcs_pkg::ERR_FEED;
                  end else begin
                     poll_count_in = '0;
                     if (b != '0 && send_offset_ff == cmd_count_ff - 1'b1) begin
                        plan_n_in    = tfcs_pkg::CHUNK_W'(1);
                        phase_in     = PH_LAST_CHECK;
                        final_vld_in = 1'b1;
                     end else if (b != '0) begin
                        feed_req = 1'b1;
                     end else begin
                        phase_in     = PH_FEED_BURST;
                        final_vld_in = 1'b1;
                     end
                  end
               end
               PH_LAST_CHECK: begin
                  if (!s[tfcs_pkg::ST_VALID]) begin
                     poll_req  = 1'b1;
                     poll_code = tfcs_pkg::ERR_END_STATUS;
                  end else if (s[tfcs_pkg::ST_EXPECT]) begin
                     fail_req  = 1'b1;
                     fail_code = tfcs_pkg::ERR_END_STATUS;
                  end else begin
                     pre_in        = 1'b1;
                     pre_action_in = tfcs_pkg::ACT_WRITE_GO;
                     final_vld_in  = 1'b1;
                     poll_count_in = '0;
                     phase_in      = PH_RESP_WAIT;
                  end
               end
               PH_RESP_WAIT: begin
                  if (!(s[tfcs_pkg::ST_VALID] && s[tfcs_pkg::ST_DATA])) begin
                     poll_req  = 1'b1;
                     poll_code = tfcs_pkg::ERR_READ_TIMEOUT;
                  end else if (b != '0) begin
                     start_req = 1'b1;
                  end else begin
                     poll_count_in = '0;
                     phase_in      = PH_RESP_BURST;
                     final_vld_in  = 1'b1;
                  end
               end
               PH_RESP_BURST: begin
                  if (b != '0) begin
                     start_req = 1'b1;
                  end else begin
                     poll_req  = 1'b1;
                     poll_code = tfcs_pkg::ERR_READ_TIMEOUT;
                  end
               end
               PH_RESP_CHECK: begin
                  if (!s[tfcs_pkg::ST_VALID]) begin
                     poll_req  = 1'b1;
                     poll_code = tfcs_pkg::ERR_READ_TIMEOUT;
                  end else if (tfcs_pkg::EXP_W'(recv_offset_ff) == limit ||
                               !s[tfcs_pkg::ST_DATA]) begin
                     fin_req = 1'b1;
                  end else if (b != '0) begin
                     start_req = 1'b1;
                  end else begin
                     poll_count_in = '0;
                     phase_in      = PH_RESP_BURST;
                     final_vld_in  = 1'b1;
                  end
               end
               PH_READY1: begin
                  if (s[tfcs_pkg::ST_READY]) begin
                     done_req = 1'b1;
                  end else begin
                     pre_in        = 1'b1;
                     pre_action_in = tfcs_pkg::ACT_WRITE_READY;
                     final_vld_in  = 1'b1;
                     poll_count_in = '0;
                     phase_in      = PH_READY2;
                  end
               end
               PH_READY2: begin
                  if (s[tfcs_pkg::ST_READY]) begin
                     done_req = 1'b1;
                  end else begin
                     poll_req  = 1'b1;
                     poll_code = tfcs_pkg::ERR_READY_TIMEOUT;
                  end
               end
               default: begin
               end
            endcase
         end
         tfcs_pkg::OP_RESP: begin
            if (phase_ff == PH_READING) begin
               // Response bytes 2 to 5 carry the big-endian total length.
               if (recv_offset_ff >= tfcs_pkg::LEN_W'(2) &&
                   recv_offset_ff < tfcs_pkg::LEN_W'(6)) begin
                  exp_nxt = {expected_len_ff[tfcs_pkg::EXP_W-9:0], in_ff.resp_byte};
               end
               limit_nxt       = (recv_nxt < tfcs_pkg::LEN_W'(6))
                                 ? tfcs_pkg::EXP_W'(cfg.capacity) : exp_nxt;
               expected_len_in = exp_nxt;
               recv_offset_in  = recv_nxt;
               read_credit_in  = credit_nxt;
               final_vld_in    = 1'b1;
               if (recv_nxt == tfcs_pkg::LEN_W'(6) &&
                   (exp_nxt < tfcs_pkg::EXP_W'(6) ||
                    exp_nxt > tfcs_pkg::EXP_W'(cfg.capacity))) begin
                  final_in  = tfcs_pkg::make_rsp(tfcs_pkg::ACT_ERROR, in_ff.resp_byte, 1'b1,
                                                 '0, tfcs_pkg::ERR_LENGTH);
                  clear_req = 1'b1;
               end else if (credit_nxt != '0 &&
                            tfcs_pkg::EXP_W'(recv_nxt) < limit_nxt) begin
                  final_in = tfcs_pkg::make_rsp(tfcs_pkg::ACT_READ_DATA, in_ff.resp_byte,
                                                1'b1, '0, tfcs_pkg::ERR_NONE);
               end else begin
                  final_in      = tfcs_pkg::make_rsp(tfcs_pkg::ACT_READ_STATUS,
                                                     in_ff.resp_byte, 1'b1, '0,
                                                     tfcs_pkg::ERR_NONE);
                  poll_count_in = '0;
                  phase_in      = PH_RESP_CHECK;
               end
            end
         end
         default: begin
         end
      endcase

      if (poll_req) begin
         if (poll_inc >= {1'b0, cfg.timeout}) begin
            fail_req  = 1'b1;
            fail_code = poll_code;
         end else begin
            poll_count_in = poll_inc[tfcs_pkg::TMO_W-1:0];
            final_vld_in  = 1'b1;
         end
      end

      if (feed_req) begin
         // Chunk length is the smallest of burst, bytes before the last one,
         // and the chunk limit.
         if (tfcs_pkg::EXP_W'(b) < n) begin
            n = tfcs_pkg::EXP_W'(b);
         end
         if (n > tfcs_pkg::EXP_W'(tfcs_pkg::CHUNK_MAX)) begin
            n = tfcs_pkg::EXP_W'(tfcs_pkg::CHUNK_MAX);
         end
         plan_n_in     = n[tfcs_pkg::CHUNK_W-1:0];
         final_vld_in  = 1'b1;
         phase_in      = PH_FEED_CHECK;
         poll_count_in = '0;
      end

      if (start_req) begin
         poll_count_in  = '0;
         read_credit_in = b;
         final_vld_in   = 1'b1;
         if (tfcs_pkg::EXP_W'(recv_offset_ff) < limit) begin
            final_in = tfcs_pkg::make_rsp(tfcs_pkg::ACT_READ_DATA, 8'd0, 1'b0, '0,
                                          tfcs_pkg::ERR_NONE);
            phase_in = PH_READING;
         end else begin
            phase_in = PH_RESP_CHECK;
         end
      end

      if (fin_req) begin
         if (s[tfcs_pkg::ST_DATA]) begin
            fail_req  = 1'b1;
            fail_code = tfcs_pkg::ERR_END_STATUS;
         end else begin
            pre_in        = 1'b1;
            pre_action_in = tfcs_pkg::ACT_WRITE_READY;
            final_vld_in  = 1'b1;
            phase_in      = PH_READY1;
            poll_count_in = '0;
         end
      end

      if (done_req) begin
         final_vld_in = 1'b1;
         final_in     = tfcs_pkg::make_rsp(tfcs_pkg::ACT_DONE, 8'd0, 1'b0, recv_offset_ff,
                                           tfcs_pkg::ERR_NONE);
         clear_req    = 1'b1;
      end

      if (fail_req) begin
         final_vld_in = 1'b1;
         final_in     = tfcs_pkg::make_rsp(tfcs_pkg::ACT_ERROR, 8'd0, 1'b0, '0, fail_code);
         clear_req    = 1'b1;
      end

      if (clear_req) begin
         phase_in        = PH_IDLE;
         cmd_count_in    = '0;
         send_offset_in  = '0;
         poll_count_in   = '0;
         read_credit_in  = '0;
         recv_offset_in  = '0;
         expected_len_in = tfcs_pkg::EXP_W'(cfg.capacity);
         pre_in          = 1'b0;
         plan_n_in       = '0;
      end

      if (!exec_en) begin
         phase_in        = phase_ff;
         cmd_count_in    = cmd_count_ff;
         poll_count_in   = poll_count_ff;
         read_credit_in  = read_credit_ff;
         recv_offset_in  = recv_offset_ff;
         expected_len_in = expected_len_ff;
         mem_we          = 1'b0;
         send_offset_in  = send_offset_ff;
         if (state_ff == S_MEMIT && out_free) begin
            send_offset_in = send_offset_ff + 1'b1;
         end
      end
   end

   // Result sequencer.
   always_comb begin
      state_in    = state_ff;
      rsp_data_in = rsp_data_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (pre_in) begin
               state_in = S_PRE;
            end else if (plan_n_in != '0) begin
               state_in = S_MREAD;
            end else if (final_vld_in) begin
               state_in = S_FINAL;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_PRE: begin
            rsp_data_in      = tfcs_pkg::make_rsp(pre_action_ff, 8'd0, 1'b0, '0,
                                                  tfcs_pkg::ERR_NONE);
            rsp_data_in.last = 1'b0;
            if (out_free) begin
               state_in = S_FINAL;
            end
         end
         S_MREAD: begin
            state_in = S_MEMIT;
         end
         S_MEMIT: begin
            rsp_data_in      = tfcs_pkg::make_rsp(tfcs_pkg::ACT_WRITE_DATA, mem_q_ff, 1'b0,
                                                  '0, tfcs_pkg::ERR_NONE);
            rsp_data_in.last = 1'b0;
            if (out_free) begin
               state_in = (plan_n_ff == tfcs_pkg::CHUNK_W'(1)) ? S_FINAL : S_MREAD;
            end
         end
         S_FINAL: begin
            rsp_data_in = final_ff;
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (!rsp_load) begin
         rsp_data_in = rsp_data_ff;
      end
   end

   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         phase_ff        <= PH_IDLE;
         cmd_count_ff    <= '0;
         send_offset_ff  <= '0;
         poll_count_ff   <= '0;
         read_credit_ff  <= '0;
         recv_offset_ff  <= '0;
         expected_len_ff <= tfcs_pkg::EXP_W'(tfcs_pkg::CAP_RESET);
         rsp_valid_ff    <= 1'b0;
         plan_n_ff       <= '0;
         final_vld_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         phase_ff        <= phase_in;
         cmd_count_ff    <= cmd_count_in;
         send_offset_ff  <= send_offset_in;
         poll_count_ff   <= poll_count_in;
         read_credit_ff  <= read_credit_in;
         recv_offset_ff  <= recv_offset_in;
         expected_len_ff <= expected_len_in;
         rsp_valid_ff    <= rsp_valid_in;
         if (exec_en) begin
            plan_n_ff    <= plan_n_in;
            final_vld_ff <= final_vld_in;
         end else if (state_ff == S_MEMIT && out_free) begin
            plan_n_ff    <= plan_n_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= req_data;
      end
      if (exec_en) begin
         pre_action_ff <= pre_action_in;
         final_ff      <= final_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   // Command store: written while collecting, read one byte per burst step.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         cmd_mem[cmd_count_ff[tfcs_pkg::ADDR_W-1:0]] <= in_ff.cmd_byte;
      end
      if (state_ff == S_MREAD) begin
         mem_q_ff <= cmd_mem[send_offset_ff[tfcs_pkg::ADDR_W-1:0]];
      end
   end

   `TFCS_ASSERT(a_busy_after_accept, clock, reset, (req_valid && req_ready) |=> !req_ready)
   `TFCS_ASSERT(a_send_in_range, clock, reset, send_offset_ff <= cmd_count_ff)
   `TFCS_ASSERT(a_idle_counts_clear, clock, reset, (phase_ff == PH_IDLE) |-> (recv_offset_ff == '0 && poll_count_ff == '0))
   `TFCS_ASSERT(a_burst_nonzero, clock, reset, (state_ff == S_MEMIT || state_ff == S_MREAD) |-> (plan_n_ff != '0 && final_vld_ff))
   `TFCS_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> (state_ff == S_IDLE && !rsp_valid_ff))

endmodule
